FILE: sv/bma_pkg.sv
package bma_pkg;

  // Fixed field widths of the stream words.
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned AVG_W    = 32;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the sample and read the oldest ring entry
    logic update;    // write the ring, update the sum, fill count and pointer
    logic div_load;  // load the divider from the running sum
    logic div_step;  // one restoring-division step
    logic out_load;  // load the result register
  } cmd_t;

endpackage

FILE: sv/bma_ctrl.sv
module bma_ctrl
  import bma_pkg::*;
#(
  parameter int unsigned DivW = 38
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  localparam int unsigned StepW = $clog2(DivW);
  localparam logic [StepW-1:0] LastStep = StepW'(DivW - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_LOAD,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e          state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic            out_valid_q, out_valid_d;

  // Command decode and next-state logic from the current state.
  always_comb begin
    cmd_o          = '0;
    state_d        = state_q;
    step_d         = step_q;
    out_valid_d    = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.div_load = 1'b1;
        step_d         = '0;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == LastStep) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        // The result register is free once its word has been taken.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State, step counter and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: sv/bma_dp.sv
module bma_dp
  import bma_pkg::*;
#(
  parameter int unsigned Window = 60,
  parameter int unsigned SumW   = 22,
  parameter int unsigned CntW   = 6,
  parameter int unsigned PtrW   = 6,
  parameter int unsigned DivW   = 38
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cmd_t                       cmd_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic signed [AVG_W-1:0]    average_o,
  output logic                       window_full_o
);

  localparam logic [CntW-1:0] WinCnt  = CntW'(Window);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Window - 1);

  // Sample ring memory with registered read.
  logic signed [SAMPLE_W-1:0] ring_mem [Window];
  logic signed [SAMPLE_W-1:0] old_q;
  logic signed [SAMPLE_W-1:0] x_q;

  logic signed [SumW-1:0] sum_q, sum_d;
  logic [CntW-1:0]        fill_q, fill_d;
  logic [PtrW-1:0]        ptr_q, ptr_d;
  logic                   full_now;

  // Divider registers.
  logic [DivW-1:0]  dvd_q, dvd_d;
  logic [CntW-1:0]  rem_q, rem_d;
  logic [CntW-1:0]  dsr_q, dsr_d;
  logic             neg_q, neg_d;
  logic             full_q, full_d;
  logic [SumW-1:0]  mag;
  logic [CntW:0]    trial;
  logic             ge;

  logic signed [AVG_W-1:0] avg_q;
  logic                    wfull_q;
  logic [AVG_W-1:0]        quo;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      x_q   <= sample_i;
      old_q <= ring_mem[ptr_q];
    end
    if (cmd_i.update) begin
      ring_mem[ptr_q] <= x_q;
    end
  end

  // Running sum, fill count and write pointer.
  always_comb begin
    full_now = (fill_q == WinCnt);
    sum_d    = sum_q;
    fill_d   = fill_q;
    ptr_d    = ptr_q;
    if (cmd_i.update) begin
      if (full_now) begin
        sum_d = sum_q - SumW'(old_q) + SumW'(x_q);
      end else begin
        sum_d  = sum_q + SumW'(x_q);
        fill_d = fill_q + 1'b1;
      end
      ptr_d = (ptr_q == LastPtr) ? '0 : ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      fill_q <= '0;
      ptr_q  <= '0;
    end else begin
      sum_q  <= sum_d;
      fill_q <= fill_d;
      ptr_q  <= ptr_d;
    end
  end

  // Restoring division of |sum| * 2^16 by the fill count, one bit a step.
  always_comb begin
    mag    = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
    trial  = {rem_q, dvd_q[DivW-1]};
    ge     = (trial >= {1'b0, dsr_q});
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    neg_d  = neg_q;
    full_d = full_q;
    if (cmd_i.div_load) begin
      dvd_d  = {mag, FRAC_W'(0)};
      rem_d  = '0;
      dsr_d  = fill_q;
      neg_d  = sum_q[SumW-1];
      full_d = full_now;
    end else if (cmd_i.div_step) begin
      dvd_d = {dvd_q[DivW-2:0], ge};
      rem_d = ge ? CntW'(trial - {1'b0, dsr_q}) : trial[CntW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
    neg_q  <= neg_d;
    full_q <= full_d;
  end

  // Result register: quotient with the sign restored.
  assign quo = dvd_q[AVG_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      avg_q   <= neg_q ? -quo : quo;
      wfull_q <= full_q;
    end
  end

  assign average_o     = avg_q;
  assign window_full_o = wfull_q;

endmodule

FILE: sv/boxcar_moving_average_with_warmup.sv
// Boxcar moving average with warm-up. Each 16-bit signed sample word returns one
// word holding the mean of the latest samples as signed fixed point with 16
// fraction bits, truncated toward zero. Until WINDOW samples have arrived the
// divisor is the number of samples seen so far; from then on it is WINDOW, and
// tuser is high. The bit-serial divider produces one quotient bit per cycle, and
// no new sample is accepted until the previous one has passed through it and
// its result has been loaded into the output register. A new sample is
// accepted while the previous result still waits in the output register, but
// the next result waits until that word has been taken.
module boxcar_moving_average_with_warmup
  import bma_pkg::*;
#(
  parameter int unsigned WINDOW = 60
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] average
  output logic        m_axis_tuser    // [0] window_full
);

  localparam int unsigned SumW = SAMPLE_W + $clog2(WINDOW);
  localparam int unsigned CntW = $clog2(WINDOW + 1);
  localparam int unsigned PtrW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned DivW = SumW + FRAC_W;

  cmd_t cmd;
  logic signed [AVG_W-1:0] average;

  bma_ctrl #(
    .DivW (DivW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  bma_dp #(
    .Window (WINDOW),
    .SumW   (SumW),
    .CntW   (CntW),
    .PtrW   (PtrW),
    .DivW   (DivW)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sample_i      (s_axis_tdata),
    .average_o     (average),
    .window_full_o (m_axis_tuser)
  );

  assign m_axis_tdata = average;

  // At most one datapath command is active in a cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.capture, cmd.update, cmd.div_load, cmd.div_step, cmd.out_load}))
    else $error("more than one datapath command active");

  // An accepted sample is written to the ring in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> cmd.update)
    else $error("accepted sample not followed by ring update");

  // The result register is never overwritten before its word is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("pending result overwritten");

  // No sample is accepted while the divider runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_step |-> !s_axis_tready)
    else $error("input ready during division");

endmodule

FILE: test/tb_boxcar_moving_average_with_warmup.sv
module tb_boxcar_moving_average_with_warmup;
  import bma_pkg::*;

  localparam int unsigned WINDOW      = 60;
  localparam int          NUM_RANDOM  = 500;
  localparam int          SETTLE_CYC  = 50;
  localparam int          STALL_LIMIT = 2000;

  // Stimulus patterns for the random part.
  typedef enum int {
    PAT_RANDOM,
    PAT_POS_MAX,
    PAT_NEG_MAX,
    PAT_NEAR_ZERO,
    PAT_ALTERNATE
  } pattern_e;

  // A sample waiting to be sent; with hold set the sender first waits
  // until every outstanding mean has come back.
  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    bit                  hold;
  } sample_item_t;

  // One expected output word.
  typedef struct {
    logic [AVG_W-1:0] average;
    logic             window_full;
  } mean_word_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [SAMPLE_W-1:0] s_axis_tdata  = '0;  // [15:0] sample
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [AVG_W-1:0]    m_axis_tdata;        // [31:0] average
  logic                m_axis_tuser;        // [0] window_full

  sample_item_t        sample_q[$];
  mean_word_t          mean_q[$];

  // Predictor state: the sample history, its sum, the fill level and the slot.
  logic signed [SAMPLE_W-1:0] hist_ring[WINDOW];
  longint              hist_sum   = 0;
  int                  hist_fill  = 0;
  int                  hist_slot  = 0;

  int                  error_cnt   = 0;
  int                  sent_cnt    = 0;
  int                  mean_cnt    = 0;
  int                  send_gap    = 0;
  int                  recv_stall  = 0;
  int                  idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  boxcar_moving_average_with_warmup #(
    .WINDOW(WINDOW)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Print one mismatch and count it.
  task automatic report_mismatch(input string what, input logic [AVG_W-1:0] got,
                                 input logic [AVG_W-1:0] want);
    $display("[%0t] mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    error_cnt++;
  endtask

  // Advance the window by one sample and queue the mean it produces.
  // SystemVerilog integer division truncates toward zero, as the block does.
  task automatic push_window_mean(input logic signed [SAMPLE_W-1:0] sample);
    longint     quotient;
    mean_word_t word;
    if (hist_fill == WINDOW) begin
      hist_sum -= hist_ring[hist_slot];
    end else begin
      hist_fill++;
    end
    hist_ring[hist_slot] = sample;
    hist_sum += sample;
    hist_slot = (hist_slot + 1) % WINDOW;
    quotient = (hist_sum * 65536) / hist_fill;
    word.average     = quotient[AVG_W-1:0];
    word.window_full = (hist_fill == WINDOW);
    mean_q.push_back(word);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(input pattern_e pat, input int idx);
    int v;
    case (pat)
      PAT_POS_MAX:   v = 32767;
      PAT_NEG_MAX:   v = -32768;
      PAT_NEAR_ZERO: v = int'($urandom_range(0, 6)) - 3;
      PAT_ALTERNATE: v = idx[0] ? 32767 : -32768;
      default:       v = int'($urandom);
    endcase
    return v[SAMPLE_W-1:0];
  endfunction

  function automatic void add_sample(input logic [SAMPLE_W-1:0] sample, input bit hold);
    sample_item_t item;
    item.sample = sample;
    item.hold   = hold;
    sample_q.push_back(item);
  endfunction

  // Idle gaps are drawn per word, with calm stretches in which the caller's side runs flat out.
  function automatic int draw_wait(input int count, input int period, input int calm_phase);
    if ((count / period) % 4 == calm_phase) return 0;
    return $urandom_range(0, 15);
  endfunction

  // Sender: presents samples from the queue and feeds accepted ones to the predictor.
  always @(posedge clk_i or negedge rst_ni) begin
    logic         valid_n;
    sample_item_t item;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      valid_n = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        push_window_mean(s_axis_tdata);
        sent_cnt++;
        valid_n  = 1'b0;
        send_gap = draw_wait(sent_cnt, 40, 3);
      end
      if (!valid_n) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (sample_q.size() != 0 && (!sample_q[0].hold || mean_q.size() == 0)) begin
          item = sample_q.pop_front();
          s_axis_tdata <= item.sample;
          valid_n = 1'b1;
        end
      end
      s_axis_tvalid <= valid_n;
    end
  end

  // Receiver: stalls at random and checks every mean word against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    logic       ready_n;
    mean_word_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      ready_n = m_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        mean_cnt++;
        if (mean_q.size() == 0) begin
          report_mismatch("unexpected word", m_axis_tdata, '0);
        end else begin
          want = mean_q.pop_front();
          if (m_axis_tdata !== want.average) begin
            report_mismatch("average", m_axis_tdata, want.average);
          end
          if (m_axis_tuser !== want.window_full) begin
            report_mismatch("window_full", AVG_W'(m_axis_tuser), AVG_W'(want.window_full));
          end
        end
        ready_n    = 1'b0;
        recv_stall = draw_wait(mean_cnt, 50, 1);
      end
      if (!ready_n) begin
        if (recv_stall != 0) begin
          recv_stall--;
        end else begin
          ready_n = 1'b1;
        end
      end
      m_axis_tready <= ready_n;
    end
  end

  // Watchdog: ends the run when no word moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int       filled;
    int       seg_len;
    bit       hold;
    pattern_e pat;

    // Directed part: the first sample alone, the extremes, small negative sums
    // that must truncate toward zero, and alternating bit patterns.
    add_sample(16'h8000, 1'b0);
    add_sample(16'h7fff, 1'b0);
    add_sample(16'h0000, 1'b0);
    add_sample(16'hffff, 1'b0);
    add_sample(16'h0001, 1'b0);
    add_sample(16'hffff, 1'b0);
    add_sample(16'h0000, 1'b0);
    add_sample(16'h0000, 1'b0);
    add_sample(16'hfffd, 1'b0);
    add_sample(16'h5555, 1'b0);
    add_sample(16'haaaa, 1'b0);
    add_sample(16'h8000, 1'b0);
    add_sample(16'h7fff, 1'b0);
    add_sample(16'hfffe, 1'b0);
    add_sample(16'h0003, 1'b0);
    add_sample(16'hfff9, 1'b0);

    // Random part: runs of one pattern, long enough to fill the window with
    // extremes now and then; some runs start only once the pipe is empty.
    filled = 0;
    hold   = 1'b1;
    while (filled < NUM_RANDOM) begin
      seg_len = $urandom_range(10, 80);
      pat     = pattern_e'($urandom_range(0, 4));
      for (int i = 0; i < seg_len; i++) begin
        add_sample(pick_sample(pat, i), hold && (i == 0));
      end
      filled += seg_len;
      hold = ($urandom_range(0, 5) == 0);
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (sample_q.size() != 0 || s_axis_tvalid || mean_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYC) @(posedge clk_i);

    if (error_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
